// ===== hw/rtl/rpe_pkg.sv =====
// Shared widths, register codes and the sine table for the edge rotate/project block.
package rpe_pkg;

  localparam int InW    = 10;
  localparam int FracW  = 8;
  localparam int CrdW   = 21;
  localparam int TrigW  = 16;
  localparam int TrigFr = 14;
  localparam int ProdW  = CrdW + TrigW;
  localparam int SumW   = ProdW + 1;
  localparam int DenW   = 26;
  localparam int NumW   = 40;
  localparam int QuoW   = 17;
  localparam int ScrW   = 16;

  localparam int AngW   = 9;
  localparam int FocW   = 12;
  localparam int VdW    = 16;
  localparam int CenW   = 12;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgAngle   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFocal   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDist    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCenterX = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCenterY = 3'd4;

  localparam logic [AngW-1:0] AngleRst   = 9'd0;
  localparam logic [FocW-1:0] FocalRst   = 12'd500;
  localparam logic [VdW-1:0]  DistRst    = 16'd1000;
  localparam logic [CenW-1:0] CenterXRst = 12'd400;
  localparam logic [CenW-1:0] CenterYRst = 12'd300;

  localparam logic signed [TrigW-1:0] TrigOne = 16'sd16384;
  localparam logic signed [ScrW-1:0]  ScrMax  = 16'sh7fff;
  localparam logic signed [ScrW-1:0]  ScrMin  = 16'sh8000;

  typedef struct packed {
    logic [FocW-1:0]          focal;
    logic [VdW-1:0]           vdist;
    logic [CenW-1:0]          cen_x;
    logic [CenW-1:0]          cen_y;
    logic signed [TrigW-1:0]  cs;
    logic signed [TrigW-1:0]  sn;
  } rpe_cfg_t;

  function automatic logic [14:0] sin_quarter(input logic [6:0] d);
    logic [14:0] r;
    unique case (d)
      7'd0: r = 15'd0;      7'd1: r = 15'd286;    7'd2: r = 15'd572;    7'd3: r = 15'd857;
      7'd4: r = 15'd1143;   7'd5: r = 15'd1428;   7'd6: r = 15'd1713;   7'd7: r = 15'd1997;
      7'd8: r = 15'd2280;   7'd9: r = 15'd2563;   7'd10: r = 15'd2845;  7'd11: r = 15'd3126;
      7'd12: r = 15'd3406;  7'd13: r = 15'd3686;  7'd14: r = 15'd3964;  7'd15: r = 15'd4240;
      7'd16: r = 15'd4516;  7'd17: r = 15'd4790;  7'd18: r = 15'd5063;  7'd19: r = 15'd5334;
      7'd20: r = 15'd5604;  7'd21: r = 15'd5872;  7'd22: r = 15'd6138;  7'd23: r = 15'd6402;
      7'd24: r = 15'd6664;  7'd25: r = 15'd6924;  7'd26: r = 15'd7182;  7'd27: r = 15'd7438;
      7'd28: r = 15'd7692;  7'd29: r = 15'd7943;  7'd30: r = 15'd8192;  7'd31: r = 15'd8438;
      7'd32: r = 15'd8682;  7'd33: r = 15'd8923;  7'd34: r = 15'd9162;  7'd35: r = 15'd9397;
      7'd36: r = 15'd9630;  7'd37: r = 15'd9860;  7'd38: r = 15'd10087; 7'd39: r = 15'd10311;
      7'd40: r = 15'd10531; 7'd41: r = 15'd10749; 7'd42: r = 15'd10963; 7'd43: r = 15'd11174;
      7'd44: r = 15'd11381; 7'd45: r = 15'd11585; 7'd46: r = 15'd11786; 7'd47: r = 15'd11982;
      7'd48: r = 15'd12176; 7'd49: r = 15'd12365; 7'd50: r = 15'd12551; 7'd51: r = 15'd12733;
      7'd52: r = 15'd12911; 7'd53: r = 15'd13085; 7'd54: r = 15'd13255; 7'd55: r = 15'd13421;
      7'd56: r = 15'd13583; 7'd57: r = 15'd13741; 7'd58: r = 15'd13894; 7'd59: r = 15'd14044;
      7'd60: r = 15'd14189; 7'd61: r = 15'd14330; 7'd62: r = 15'd14466; 7'd63: r = 15'd14598;
      7'd64: r = 15'd14726; 7'd65: r = 15'd14849; 7'd66: r = 15'd14968; 7'd67: r = 15'd15082;
      7'd68: r = 15'd15191; 7'd69: r = 15'd15296; 7'd70: r = 15'd15396; 7'd71: r = 15'd15491;
      7'd72: r = 15'd15582; 7'd73: r = 15'd15668; 7'd74: r = 15'd15749; 7'd75: r = 15'd15826;
      7'd76: r = 15'd15897; 7'd77: r = 15'd15964; 7'd78: r = 15'd16026; 7'd79: r = 15'd16083;
      7'd80: r = 15'd16135; 7'd81: r = 15'd16182; 7'd82: r = 15'd16225; 7'd83: r = 15'd16262;
      7'd84: r = 15'd16294; 7'd85: r = 15'd16322; 7'd86: r = 15'd16344; 7'd87: r = 15'd16362;
      7'd88: r = 15'd16374; 7'd89: r = 15'd16382; 7'd90: r = 15'd16384;
      default: r = 15'd0;
    endcase
    return r;
  endfunction

  // d is already reduced to 0..359
  function automatic logic signed [TrigW-1:0] sin_deg(input logic [AngW-1:0] d);
    logic [14:0] m;
    logic        neg;
    neg = 1'b0;
    priority if (d <= 9'd90) begin
      m = sin_quarter(7'(d));
    end else if (d <= 9'd180) begin
      m = sin_quarter(7'(9'd180 - d));
    end else if (d <= 9'd270) begin
      m   = sin_quarter(7'(d - 9'd180));
      neg = 1'b1;
    end else begin
      m   = sin_quarter(7'(9'd360 - d));
      neg = 1'b1;
    end
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage

// ===== hw/rtl/rpe_edge_if.sv =====
// Input channel carrying one edge per beat.
interface rpe_edge_if;
  import rpe_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [InW-1:0] start_x;
  logic signed [InW-1:0] start_y;
  logic signed [InW-1:0] start_z;
  logic signed [InW-1:0] end_x;
  logic signed [InW-1:0] end_y;
  logic signed [InW-1:0] end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z, input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z, output ready);
endinterface

// ===== hw/rtl/rpe_scr_if.sv =====
// Output channel carrying one projected edge per beat.
interface rpe_scr_if;
  import rpe_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [ScrW-1:0] screen_start_x;
  logic signed [ScrW-1:0] screen_start_y;
  logic signed [ScrW-1:0] screen_end_x;
  logic signed [ScrW-1:0] screen_end_y;
  modport source (output valid, screen_start_x, screen_start_y, screen_end_x, screen_end_y,
                  input ready);
  modport sink   (input valid, screen_start_x, screen_start_y, screen_end_x, screen_end_y,
                  output ready);
endinterface

// ===== hw/rtl/rpe_cfg_if.sv =====
// Register write channel.
interface rpe_cfg_if;
  import rpe_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rpe_div.sv =====
// Pipelined restoring divider with truncation toward zero and 16-bit saturation.
module rpe_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [rpe_pkg::NumW-1:0] num_i,
  input  logic signed [rpe_pkg::DenW-1:0] den_i,
  output logic                           valid_o,
  output logic signed [rpe_pkg::ScrW-1:0] res_o
);
  import rpe_pkg::*;

  localparam int RW = NumW + QuoW + 1;

  logic [NumW-1:0] na_q;
  logic [DenW-1:0] da_q;
  logic            neg0_q;
  logic            v0_q;

  logic [RW-1:0]   rem_q [0:QuoW];
  logic [QuoW-1:0] quo_q [0:QuoW];
  logic [DenW-1:0] dv_q  [0:QuoW];
  logic            neg_q [0:QuoW];
  logic            ovf_q [0:QuoW];
  logic            vld_q [0:QuoW];

  logic                   vo_q;
  logic signed [ScrW-1:0] res_q, res_d;
  logic [QuoW-1:0]        qn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      vo_q <= vld_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na_q   <= num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
      da_q   <= den_i[DenW-1] ? DenW'(-den_i) : DenW'(den_i);
      neg0_q <= num_i[NumW-1] ^ den_i[DenW-1];
      rem_q[0] <= RW'(na_q);
      quo_q[0] <= '0;
      dv_q[0]  <= da_q;
      neg_q[0] <= neg0_q;
      // zero divisor lands here too and saturates by the numerator sign
      ovf_q[0] <= RW'(na_q) >= (RW'(da_q) << QuoW);
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= v0_q;
    end
  end

  for (genvar j = 1; j <= QuoW; j++) begin : g_step
    localparam int Sh = QuoW - j;
    logic [RW-1:0] trial;
    logic          take;
    assign trial = RW'(dv_q[j-1]) << Sh;
    assign take  = rem_q[j-1] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? rem_q[j-1] - trial : rem_q[j-1];
        quo_q[j] <= quo_q[j-1] | (QuoW'(take) << Sh);
        dv_q[j]  <= dv_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end
  end

  assign qn = QuoW'(0) - quo_q[QuoW];

  always_comb begin
    priority if (ovf_q[QuoW]) begin
      res_d = neg_q[QuoW] ? ScrMin : ScrMax;
    end else if (neg_q[QuoW]) begin
      res_d = (quo_q[QuoW] > QuoW'(32768)) ? ScrMin : $signed(qn[ScrW-1:0]);
    end else begin
      res_d = (quo_q[QuoW] > QuoW'(32767)) ? ScrMax : $signed(quo_q[QuoW][ScrW-1:0]);
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

endmodule

// ===== hw/rtl/rpe_lane.sv =====
// One vertex lane: three rotation stages, perspective numerator and two dividers.
module rpe_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [rpe_pkg::InW-1:0]  x_i,
  input  logic signed [rpe_pkg::InW-1:0]  y_i,
  input  logic signed [rpe_pkg::InW-1:0]  z_i,
  input  rpe_pkg::rpe_cfg_t               cfg_i,
  output logic                            valid_o,
  output logic signed [rpe_pkg::ScrW-1:0] scr_x_o,
  output logic signed [rpe_pkg::ScrW-1:0] scr_y_o
);
  import rpe_pkg::*;

  localparam int ExtW = CrdW - InW - FracW;
  localparam logic signed [SumW-1:0] Half = SumW'(1) <<< (TrigFr - 1);

  logic signed [CrdW-1:0] crd_q [0:3][0:2];
  logic                   vs_q  [0:3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      crd_q[0][0] <= $signed({{ExtW{x_i[InW-1]}}, x_i, {FracW{1'b0}}});
      crd_q[0][1] <= $signed({{ExtW{y_i[InW-1]}}, y_i, {FracW{1'b0}}});
      crd_q[0][2] <= $signed({{ExtW{z_i[InW-1]}}, z_i, {FracW{1'b0}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q[0] <= 1'b0;
    end else if (en_i) begin
      vs_q[0] <= valid_i;
    end
  end

  // rotate about Z, then Y, then X
  for (genvar k = 0; k < 3; k++) begin : g_rot
    localparam int IA = (k == 0) ? 0 : ((k == 1) ? 2 : 1);
    localparam int IB = (k == 0) ? 1 : ((k == 1) ? 0 : 2);
    localparam int IK = 2 - k;

    logic signed [ProdW-1:0] pac_q, pbs_q, pas_q, pbc_q;
    logic signed [CrdW-1:0]  keep_q;
    logic                    vp_q;
    logic signed [SumW-1:0]  sa, sb;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pac_q  <= crd_q[k][IA] * cfg_i.cs;
        pbs_q  <= crd_q[k][IB] * cfg_i.sn;
        pas_q  <= crd_q[k][IA] * cfg_i.sn;
        pbc_q  <= crd_q[k][IB] * cfg_i.cs;
        keep_q <= crd_q[k][IK];
      end
    end

    assign sa = SumW'(pac_q) - SumW'(pbs_q) + Half;
    assign sb = SumW'(pas_q) + SumW'(pbc_q) + Half;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        crd_q[k+1][IA] <= CrdW'(sa >>> TrigFr);
        crd_q[k+1][IB] <= CrdW'(sb >>> TrigFr);
        crd_q[k+1][IK] <= keep_q;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vp_q      <= 1'b0;
        vs_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vp_q      <= vs_q[k];
        vs_q[k+1] <= vp_q;
      end
    end
  end

  logic signed [CrdW-1:0] px0_q, py0_q;
  logic signed [DenW-1:0] den0_q, den1_q, den2_q;
  logic signed [NumW-1:0] mx_q, my_q, mcx_q, mcy_q, numx_q, numy_q;
  logic                   vj0_q, vj1_q, vj2_q;
  logic                   vdx, vdy;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px0_q  <= crd_q[3][0];
      py0_q  <= crd_q[3][1];
      den0_q <= DenW'(crd_q[3][2]) + $signed({2'b00, cfg_i.vdist, {FracW{1'b0}}});
      mx_q   <= px0_q * $signed({1'b0, cfg_i.focal});
      my_q   <= py0_q * $signed({1'b0, cfg_i.focal});
      mcx_q  <= $signed({1'b0, cfg_i.cen_x}) * den0_q;
      mcy_q  <= $signed({1'b0, cfg_i.cen_y}) * den0_q;
      den1_q <= den0_q;
      numx_q <= mx_q + mcx_q;
      numy_q <= my_q + mcy_q;
      den2_q <= den1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vj0_q <= 1'b0;
      vj1_q <= 1'b0;
      vj2_q <= 1'b0;
    end else if (en_i) begin
      vj0_q <= vs_q[3];
      vj1_q <= vj0_q;
      vj2_q <= vj1_q;
    end
  end

  rpe_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vj2_q),
    .num_i   (numx_q),
    .den_i   (den2_q),
    .valid_o (vdx),
    .res_o   (scr_x_o)
  );

  rpe_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vj2_q),
    .num_i   (numy_q),
    .den_i   (den2_q),
    .valid_o (vdy),
    .res_o   (scr_y_o)
  );

  assign valid_o = vdx & vdy;

endmodule

// ===== hw/rtl/rotate_project_edge.sv =====
// Top level: registers, trig lookup, two vertex lanes and the merging output register.
// From an accepted edge beat to the matching output beat the path holds 1 input,
// 6 rotation, 3 numerator and 20 divider stages (17 quotient steps) plus the output register.
// Throughput: one edge per cycle unless the output stalls; both vertices run in their own
// lane, each with a pipelined divider per screen axis, so the divider depth sets the latency.
// A stalled output beat freezes the whole pipeline in place; nothing is dropped.
// Reset: registers take their reset values, and the trig outputs reset to sine 0, cosine one.
module rotate_project_edge (
  input  logic            clk_i,
  input  logic            rst_ni,
  rpe_edge_if.sink        in_i,
  rpe_scr_if.source       out_o,
  rpe_cfg_if.sink         cfg_i
);
  import rpe_pkg::*;

  logic [AngW-1:0] angle_q;
  logic [FocW-1:0] focal_q;
  logic [VdW-1:0]  dist_q;
  logic [CenW-1:0] cen_x_q, cen_y_q;
  logic signed [TrigW-1:0] sn_q, cs_q;
  logic [AngW-1:0] ang_m, ang_c;
  rpe_cfg_t        lane_cfg;
  logic            en;
  logic            v0, v1;
  logic signed [ScrW-1:0] s0x, s0y, s1x, s1y;
  logic            out_v_q;
  logic signed [ScrW-1:0] o0x_q, o0y_q, o1x_q, o1y_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= AngleRst;
      focal_q <= FocalRst;
      dist_q  <= DistRst;
      cen_x_q <= CenterXRst;
      cen_y_q <= CenterYRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgAngle:   angle_q <= cfg_i.data[AngW-1:0];
        CfgFocal:   focal_q <= cfg_i.data[FocW-1:0];
        CfgDist:    dist_q  <= cfg_i.data[VdW-1:0];
        CfgCenterX: cen_x_q <= cfg_i.data[CenW-1:0];
        CfgCenterY: cen_y_q <= cfg_i.data[CenW-1:0];
        default: ;
      endcase
    end
  end

  // reduce the angle mod 360, cosine is sine shifted by a quarter turn
  assign ang_m = (angle_q >= 9'd360) ? angle_q - 9'd360 : angle_q;
  assign ang_c = (ang_m >= 9'd270) ? ang_m - 9'd270 : ang_m + 9'd90;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sn_q <= '0;
      cs_q <= TrigOne;
    end else begin
      sn_q <= sin_deg(ang_m);
      cs_q <= sin_deg(ang_c);
    end
  end

  assign lane_cfg = '{focal: focal_q, vdist: dist_q, cen_x: cen_x_q, cen_y: cen_y_q,
                      cs: cs_q, sn: sn_q};

  // advance while the output register is empty or being drained
  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  rpe_lane u_lane_start (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .x_i     (in_i.start_x),
    .y_i     (in_i.start_y),
    .z_i     (in_i.start_z),
    .cfg_i   (lane_cfg),
    .valid_o (v0),
    .scr_x_o (s0x),
    .scr_y_o (s0y)
  );

  rpe_lane u_lane_end (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .x_i     (in_i.end_x),
    .y_i     (in_i.end_y),
    .z_i     (in_i.end_z),
    .cfg_i   (lane_cfg),
    .valid_o (v1),
    .scr_x_o (s1x),
    .scr_y_o (s1y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v0 & v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o0x_q <= s0x;
      o0y_q <= s0y;
      o1x_q <= s1x;
      o1y_q <= s1y;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.screen_start_x = o0x_q;
  assign out_o.screen_start_y = o0y_q;
  assign out_o.screen_end_x   = o1x_q;
  assign out_o.screen_end_y   = o1y_q;

  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni) v0 == v1)
    else $error("vertex lanes out of step");

  a_stall_holds_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_o.ready) |=> ($stable(v0) && $stable(s0x) && $stable(s1y)))
    else $error("lane result moved during output stall");

  a_zero_angle_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (angle_q == '0) |=> (sn_q == '0 && cs_q == TrigOne))
    else $error("trig lookup wrong for zero angle");

endmodule
